// ----- src/skit_pkg.sv -----
package skit_pkg;

   // fixed field widths
   localparam int KEY_W    = 64;
   localparam int REC_W    = 8;
   localparam int ACTION_W = 2;
   localparam int REQ_W    = 72;
   localparam int RSP_W    = 16;

   // default table size
   localparam int CAPACITY_DEF = 128;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_INSERT,
      ST_SEARCH,
      ST_SHIFT,
      ST_FINISH
   } skit_state_type;

   // strobes from the sequencer to every cell
   typedef struct packed {
      logic compare;
      logic insert;
      logic scan_load;
      logic scan_shift;
   } skit_cell_ctl_type;

endpackage

// ----- src/skit_cell.sv -----
module skit_cell #(
   parameter int CAPACITY = skit_pkg::CAPACITY_DEF,
   parameter int INDEX    = 0
) (
   input  logic                              clock,
   input  skit_pkg::skit_cell_ctl_type       ctl,
   input  logic [skit_pkg::KEY_W-1:0]        search_key,
   input  logic [skit_pkg::REC_W-1:0]        new_rec,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic [skit_pkg::KEY_W-1:0]        prev_key,
   input  logic [skit_pkg::REC_W-1:0]        prev_rec,
   input  logic                              prev_gt,
   input  logic [skit_pkg::REC_W-1:0]        next_scan,
   output logic [skit_pkg::KEY_W-1:0]        key_out,
   output logic [skit_pkg::REC_W-1:0]        rec_out,
   output logic                              gt,
   output logic                              eq,
   output logic [skit_pkg::REC_W-1:0]        scan
);
   import skit_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [REC_W-1:0] rec_ff, rec_in;
   logic             gt_ff, gt_in;
   logic             eq_ff, eq_in;
   logic [REC_W-1:0] scan_ff, scan_in;
   logic             valid;
   logic             at_end;

   // this cell holds an entry when its place is below the fill count
   assign valid  = CW'(INDEX) < count;
   assign at_end = CW'(INDEX) == count;

   // compare against the search key, all cells at once
   always_comb begin
      gt_in = gt_ff;
      eq_in = eq_ff;
      if (ctl.compare) begin
         gt_in = valid && (key_ff > search_key);
         eq_in = valid && (key_ff == search_key);
      end
   end

   // insertion: larger entries move up one place, the new key lands in the gap
   always_comb begin
      key_in = key_ff;
      rec_in = rec_ff;
      if (ctl.insert) begin
         if (prev_gt) begin
            key_in = prev_key;
            rec_in = prev_rec;
         end else if (gt_ff || at_end) begin
            key_in = search_key;
            rec_in = new_rec;
         end
      end
   end

   // readout line moves record numbers down toward cell zero
   always_comb begin
      scan_in = scan_ff;
      if (ctl.scan_load) begin
         scan_in = rec_ff;
      end else if (ctl.scan_shift) begin
         scan_in = next_scan;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      rec_ff  <= rec_in;
      gt_ff   <= gt_in;
      eq_ff   <= eq_in;
      scan_ff <= scan_in;
   end

   assign key_out = key_ff;
   assign rec_out = rec_ff;
   assign gt      = gt_ff;
   assign eq      = eq_ff;
   assign scan    = scan_ff;

endmodule

// ----- src/skit_ctrl.sv -----
module skit_ctrl #(
   parameter int CAPACITY = skit_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [skit_pkg::ACTION_W-1:0]     req_action,
   input  logic [skit_pkg::KEY_W-1:0]        req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [skit_pkg::REC_W-1:0]        rsp_rec,
   output logic                              rsp_full,
   output skit_pkg::skit_cell_ctl_type       cell_ctl,
   output logic [skit_pkg::KEY_W-1:0]        search_key,
   output logic [skit_pkg::REC_W-1:0]        new_rec,
   output logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic [CAPACITY-1:0]               gt_vec,
   input  logic [CAPACITY-1:0]               eq_vec,
   input  logic [skit_pkg::REC_W-1:0]        scan_rec
);
   import skit_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);
   localparam int AW = $clog2(CAPACITY);

   skit_state_type      state_ff, state_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       low_ff, low_in;
   logic [CW-1:0]       hp_ff, hp_in;
   logic [AW-1:0]       shift_ff, shift_in;
   logic                res_found_ff, res_found_in;
   logic [REC_W-1:0]    res_rec_ff, res_rec_in;
   logic                res_full_ff, res_full_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_found_ff, out_found_in;
   logic [REC_W-1:0]    out_rec_ff, out_rec_in;
   logic                out_full_ff, out_full_in;

   logic                full;
   logic [CW:0]         mid_sum;
   logic [AW-1:0]       mid;
   logic                span_empty;
   logic                out_free;
   logic [CW:0]         rec_wide;

   assign full       = count_ff == CW'(CAPACITY);
   // search window is [low, hp-1]; midpoint rounds down
   assign mid_sum    = {1'b0, low_ff} + {1'b0, hp_ff} - (CW+1)'(1);
   assign mid        = AW'(mid_sum >> 1);
   assign span_empty = low_ff >= hp_ff;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign rec_wide   = {1'b0, count_ff} + (CW+1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_APPEND: state_in = full ? ST_FINISH : ST_COMPARE;
                  ACT_LOOKUP: state_in = ST_COMPARE;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_COMPARE: state_in = (action_ff == ACT_APPEND) ? ST_INSERT : ST_SEARCH;
         ST_INSERT:  state_in = ST_FINISH;
         ST_SEARCH: begin
            if (span_empty) begin
               state_in = ST_FINISH;
            end else if (eq_vec[mid]) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (shift_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      cell_ctl     = '0;
      action_in    = action_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      hp_in        = hp_ff;
      shift_in     = shift_ff;
      res_found_in = res_found_ff;
      res_rec_in   = res_rec_ff;
      res_full_in  = res_full_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_found_in = out_found_ff;
      out_rec_in   = out_rec_ff;
      out_full_in  = out_full_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in    = req_action;
               key_in       = req_key;
               res_found_in = 1'b0;
               res_rec_in   = '0;
               res_full_in  = 1'b0;
               low_in       = '0;
               hp_in        = count_ff;
               if (req_action == ACT_CLEAR) begin
                  count_in = '0;
               end
               if (req_action == ACT_APPEND && full) begin
                  res_full_in = 1'b1;
               end
            end
         end
         ST_COMPARE: begin
            cell_ctl.compare   = 1'b1;
            cell_ctl.scan_load = 1'b1;
         end
         ST_INSERT: begin
            cell_ctl.insert = 1'b1;
            count_in        = count_ff + CW'(1);
            res_found_in    = 1'b1;
            res_rec_in      = REC_W'(rec_wide);
         end
         ST_SEARCH: begin
            if (!span_empty) begin
               if (eq_vec[mid]) begin
                  shift_in = mid;
               end else if (gt_vec[mid]) begin
                  hp_in = CW'(mid);
               end else begin
                  low_in = CW'(mid) + CW'(1);
               end
            end
         end
         ST_SHIFT: begin
            if (shift_ff == '0) begin
               res_found_in = 1'b1;
               res_rec_in   = scan_rec;
            end else begin
               cell_ctl.scan_shift = 1'b1;
               shift_in            = shift_ff - AW'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_found_in = res_found_ff;
               out_rec_in   = res_rec_ff;
               out_full_in  = res_full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      action_ff    <= action_in;
      key_ff       <= key_in;
      low_ff       <= low_in;
      hp_ff        <= hp_in;
      shift_ff     <= shift_in;
      res_found_ff <= res_found_in;
      res_rec_ff   <= res_rec_in;
      res_full_ff  <= res_full_in;
      out_found_ff <= out_found_in;
      out_rec_ff   <= out_rec_in;
      out_full_ff  <= out_full_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_found  = out_found_ff;
   assign rsp_rec    = out_rec_ff;
   assign rsp_full   = out_full_ff;
   assign search_key = key_ff;
   assign new_rec    = res_rec_in;
   assign count      = count_ff;

endmodule

// ----- src/sorted_key_index_table.sv -----
// Sorted key index table: up to CAPACITY 64-bit keys kept in ascending order in
// a row of cells, each key paired with the record number it got on append.
// Request channel (req_): one word per command, action clear, append or
// lookup, and the key. Response channel (rsp_): exactly one word per command
// with found, record_number and table_full.
// One command is worked on at a time; req_tready is high only while the
// sequencer is idle.
// From accept to response word: clear and unused codes go straight to the
// finish state; append does a compare in every cell, then one
// shift-and-insert step along the row; a dropped append on a full table goes
// straight to the finish state; lookup does a compare, then binary search
// steps over the per-cell compare flags (at most log2(CAPACITY)+1 on a hit,
// one more on a miss for the empty-window check), and on a hit walks the
// record down the readout line from the hit position, one cell per cycle (up
// to CAPACITY-1 cells).
// Reset empties the table (fill count to zero) and drops any pending response.
// A finished response waits in the output register while rsp_tready is low;
// the next command is taken meanwhile, but its result waits for the register.
module sorted_key_index_table #(
   parameter int CAPACITY = skit_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] action, [65:2] key, [71:66] zero
   input  logic [skit_pkg::REQ_W-1:0]     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] found, [8:1] record_number, [9] table_full, [15:10] zero
   output logic [skit_pkg::RSP_W-1:0]     rsp_tdata
);
   import skit_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);

   skit_cell_ctl_type cell_ctl;
   logic [KEY_W-1:0]  search_key;
   logic [REC_W-1:0]  new_rec;
   logic [CW-1:0]     count;
   logic [CAPACITY-1:0] gt_vec;
   logic [CAPACITY-1:0] eq_vec;
   logic [KEY_W-1:0]  key_w  [CAPACITY];
   logic [REC_W-1:0]  rec_w  [CAPACITY];
   logic [REC_W-1:0]  scan_w [CAPACITY];
   logic              rsp_found;
   logic [REC_W-1:0]  rsp_rec;
   logic              rsp_full;

   // sequencer
   skit_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tdata[ACTION_W-1:0]),
      .req_key    (req_tdata[ACTION_W+KEY_W-1:ACTION_W]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_found  (rsp_found),
      .rsp_rec    (rsp_rec),
      .rsp_full   (rsp_full),
      .cell_ctl   (cell_ctl),
      .search_key (search_key),
      .new_rec    (new_rec),
      .count      (count),
      .gt_vec     (gt_vec),
      .eq_vec     (eq_vec),
      .scan_rec   (scan_w[0])
   );

   // row of cells, each linked to its lower and upper neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic [REC_W-1:0] prev_rec;
      logic             prev_gt;
      logic [REC_W-1:0] next_scan;

      if (i == 0) begin : g_first
         assign prev_key = '0;
         assign prev_rec = '0;
         assign prev_gt  = 1'b0;
      end else begin : g_mid
         assign prev_key = key_w[i-1];
         assign prev_rec = rec_w[i-1];
         assign prev_gt  = gt_vec[i-1];
      end

      if (i == CAPACITY-1) begin : g_last
         assign next_scan = '0;
      end else begin : g_body
         assign next_scan = scan_w[i+1];
      end

      skit_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .search_key (search_key),
         .new_rec    (new_rec),
         .count      (count),
         .prev_key   (prev_key),
         .prev_rec   (prev_rec),
         .prev_gt    (prev_gt),
         .next_scan  (next_scan),
         .key_out    (key_w[i]),
         .rec_out    (rec_w[i]),
         .gt         (gt_vec[i]),
         .eq         (eq_vec[i]),
         .scan       (scan_w[i])
      );
   end

   // response word packing
   assign rsp_tdata = {6'b0, rsp_full, rsp_rec, rsp_found};

endmodule

// ----- src/skit_checker.sv -----
module skit_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [skit_pkg::REQ_W-1:0]     req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [skit_pkg::RSP_W-1:0]     rsp_tdata
);
   import skit_pkg::*;

   // a stalled response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   // one command at a time: ready drops right after an accept
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in work");

   // a word never reports both a hit and a dropped append
   a_found_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[9]))
      else $error("found and table_full both set");

   // no record number without a hit
   a_rec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == '0)
      else $error("record number set on a miss");

   // a fresh response is never offered right after a command is accepted
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response word appeared without work time");

endmodule

bind sorted_key_index_table skit_checker u_skit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
